>>> hw/rtl/ske_pkg.sv
// Shared types and codes for the sorted key set engine.
// No dependencies; imported by ske_cell and sorted_key_set_engine.
`timescale 1ns / 1ps
`default_nettype none

package ske_pkg;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 9;
    localparam int CNT_W    = 9;

    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 2'd3;

    localparam logic [2:0] ADDR_MAX_COUNT = 3'd0;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INS,
        SH_DEL
    } shift_t;

    typedef struct packed {
        logic             cmp_en;
        shift_t           shift;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_key_set_engine.sv
// Top level of the sorted key set engine: stream ports, APB register,
// control and the chain of ske_cell entries. Depends on ske_pkg, ske_cell.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tuser func, tdata key, position
//  m_*      | out       | m_tvalid/m_tready | tuser status, tdata slot, key, count
//  apb      | in        | psel/penable      | max_count at byte address 0
//
// A transaction has an accept and an update step: at the accept edge every
// cell compares its key with the request; in the update cycle the compare
// flags are encoded into slot and hit, and the chain shifts all entries at
// once. A stalled result holds the engine in the update cycle until the
// output register frees; a waiting result does not block the next accept.
// Reset clears the count and the output valid; key storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_set_engine
    import ske_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  wire         clk,
    input  wire         rst_n,
    // s_tdata: key[31:0], position[39:32]
    input  wire  [39:0] s_tdata,
    // s_tuser: func[1:0]
    input  wire  [1:0]  s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // m_tdata: slot[8:0], key_out[40:9], entries[49:41], zero above
    output logic [55:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CNT_W-1:0]    max_count_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                m_tvalid_reg;
    logic [55:0]         m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [KEY_W-1:0]    cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_ge;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_sel;
    logic [CAPACITY-1:0] cell_vld;
    cell_ctrl_t          ctrl;

    logic                accept;
    logic                can_out;
    logic                hit;
    logic                any_bnd;
    logic [LW-1:0]       slot_enc;
    logic [KEY_W-1:0]    rd_key;
    logic [LW-1:0]       slot_val;
    logic [LW-1:0]       count_l;
    logic [LW-1:0]       limit_l;
    logic [STATUS_W-1:0] status_next;
    logic [LW-1:0]       slot_next;
    logic [KEY_W-1:0]    kout_next;
    logic [CW-1:0]       count_next;
    shift_t              shift_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign can_out  = !m_tvalid_reg || m_tready;
    assign count_l  = LW'(count_reg);
    assign limit_l  = (LW'(max_count_reg) < CAP_L) ? LW'(max_count_reg) : CAP_L;

    // Encode the first entry not below the key, the match and the read data
    always_comb
    begin
        hit      = 1'b0;
        any_bnd  = 1'b0;
        slot_enc = '0;
        rd_key   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_ge[i] && ((i == 0) || !cell_ge[(i == 0) ? 0 : i - 1]))
            begin
                any_bnd  = 1'b1;
                slot_enc = slot_enc | LW'(i);
            end
            hit    = hit | cell_eq[i];
            rd_key = rd_key | (cell_sel[i] ? cell_key[i] : '0);
        end
        slot_val = any_bnd ? slot_enc : CAP_L;
    end

    always_comb
    begin
        status_next = hit ? ST_PRESENT : ST_ABSENT;
        slot_next   = slot_val;
        kout_next   = '0;
        count_next  = count_reg;
        shift_next  = SH_HOLD;
        if (func_reg == FUNC_READ)
        begin
            slot_next = LW'(pos_reg);
            if (LW'(pos_reg) < count_l)
            begin
                status_next = ST_PRESENT;
                kout_next   = rd_key;
            end
            else
            begin
                status_next = ST_BAD_IDX;
            end
        end
        else if ((func_reg == FUNC_ADD) && !hit)
        begin
            if (count_l >= limit_l)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                shift_next = SH_INS;
                count_next = count_reg + CW'(1);
            end
        end
        else if ((func_reg == FUNC_REMOVE) && hit)
        begin
            shift_next = SH_DEL;
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        ctrl.cmp_en = accept;
        ctrl.shift  = ((state_reg == S_UPD) && can_out) ? shift_next : SH_HOLD;
        ctrl.key    = (state_reg == S_IDLE) ? s_tdata[31:0] : key_reg;
        ctrl.pos    = s_tdata[39:32];
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_W-1:0] lk;
            logic             lg;
            logic [KEY_W-1:0] rk;

            assign cell_vld[g] = (CW'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign lk = ctrl.key;
                assign lg = 1'b0;
            end
            else
            begin : g_mid
                assign lk = cell_key[g-1];
                assign lg = cell_ge[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign rk = cell_key[g];
            end
            else
            begin : g_body
                assign rk = cell_key[g+1];
            end

            ske_cell #(
                .IDX (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .vld       (cell_vld[g]),
                .left_key  (lk),
                .left_ge   (lg),
                .right_key (rk),
                .key_q     (cell_key[g]),
                .ge_q      (cell_ge[g]),
                .eq_q      (cell_eq[g]),
                .sel_q     (cell_sel[g])
            );
        end
    endgenerate

    // Request registers carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            key_reg  <= s_tdata[31:0];
            pos_reg  <= s_tdata[39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_count_reg <= 9'd256;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr == ADDR_MAX_COUNT))
            begin
                max_count_reg <= pwdata[CNT_W-1:0];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    // Hold until the output register can take the result
                    if (can_out)
                    begin
                        state_reg    <= S_IDLE;
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_next;
                        m_tdata_reg  <= {6'd0, 9'(LW'(count_next)), kout_next,
                                         9'(slot_next)};
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_MAX_COUNT) ? {23'd0, max_count_reg} : 32'd0;

endmodule

`default_nettype wire

>>> hw/rtl/ske_cell.sv
// One entry of the sorted key chain: holds a key, compares it against the
// request and shifts to or from its neighbors. Depends on ske_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ske_cell
    import ske_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire              clk,
    input  cell_ctrl_t       ctrl,
    input  wire              vld,
    input  wire  [KEY_W-1:0] left_key,
    input  wire              left_ge,
    input  wire  [KEY_W-1:0] right_key,
    output logic [KEY_W-1:0] key_q,
    output logic             ge_q,
    output logic             eq_q,
    output logic             sel_q
);

    localparam logic [POS_W-1:0] POS_ID = POS_W'(IDX);
    localparam bit               POS_OK = (IDX < (1 << POS_W));

    logic [KEY_W-1:0] key_reg;
    logic             ge_reg;
    logic             eq_reg;
    logic             sel_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            // Empty entries count as not below the key
            ge_reg  <= !(vld && (key_reg < ctrl.key));
            eq_reg  <= vld && (key_reg == ctrl.key);
            sel_reg <= POS_OK && (ctrl.pos == POS_ID);
        end

        case (ctrl.shift)
            SH_INS:
            begin
                if (ge_reg)
                begin
                    key_reg <= left_ge ? left_key : ctrl.key;
                end
            end
            SH_DEL:
            begin
                if (ge_reg)
                begin
                    key_reg <= right_key;
                end
            end
            default:
            begin
                key_reg <= key_reg;
            end
        endcase
    end

    assign key_q = key_reg;
    assign ge_q  = ge_reg;
    assign eq_q  = eq_reg;
    assign sel_q = sel_reg;

endmodule

`default_nettype wire

>>> dv/tb_sorted_key_set_engine.sv
// Self-checking testbench for sorted_key_set_engine: directed and random requests
// on the stream port, register writes over APB, result checks against a local model.
// Depends on ske_pkg and the RTL of sorted_key_set_engine.
`timescale 1ns / 1ps

module tb_sorted_key_set_engine;
    import ske_pkg::*;

    localparam int STORE_DEPTH = 256;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  pos;
        bit                drain;   // hold until every open result has come back
    } set_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key_out;
        logic [CNT_W-1:0]    entries;
    } set_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [39:0] s_tdata  = '0;    // key[31:0], position[39:32]
    logic [1:0]  s_tuser  = '0;    // func[1:0]
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] m_tdata;          // slot[8:0], key_out[40:9], entries[49:41], zero above
    logic [1:0]  m_tuser;          // status[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the set: keys in ascending order, fill and capacity limit in use
    logic [KEY_W-1:0] set_keys [0:STORE_DEPTH-1];
    int               set_fill  = 0;
    int               set_limit = 256;

    set_request_t pending_q [$];
    set_result_t  expected_q [$];
    set_request_t cur_req;
    logic [KEY_W-1:0] key_pool [$];

    int sent_cnt   = 0;
    int recv_cnt   = 0;
    int err_cnt    = 0;
    int gap_left   = 0;
    int stall_left = 0;
    bit src_gaps   = 1'b1;
    bit snk_stalls = 1'b1;

    sorted_key_set_engine #(.CAPACITY(STORE_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the model set and return the result it yields
    function automatic set_result_t apply_request(set_request_t rq);
        set_result_t res;
        int          lo;
        int          hi;
        int          mid;
        int          lim;
        int          i;
        bit          hit;
        lim = (set_limit < STORE_DEPTH) ? set_limit : STORE_DEPTH;
        res.key_out = '0;
        if (rq.func == FUNC_READ) begin
            res.slot = SLOT_W'(rq.pos);
            if (rq.pos < set_fill) begin
                res.status  = ST_PRESENT;
                res.key_out = set_keys[rq.pos];
            end
            else begin
                res.status = ST_BAD_IDX;
            end
        end
        else begin
            // lower bound: first entry not below the key
            lo = 0;
            hi = set_fill;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (set_keys[mid] < rq.key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            hit = (lo < set_fill) && (set_keys[lo] == rq.key);
            res.slot   = SLOT_W'(lo);
            res.status = hit ? ST_PRESENT : ST_ABSENT;
            if (rq.func == FUNC_ADD && !hit) begin
                if (set_fill >= lim) begin
                    res.status = ST_OVERFLOW;
                end
                else begin
                    for (i = set_fill; i > lo; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[lo] = rq.key;
                    set_fill++;
                end
            end
            else if (rq.func == FUNC_REMOVE && hit) begin
                for (i = lo; i < set_fill - 1; i++)
                    set_keys[i] = set_keys[i+1];
                set_fill--;
            end
        end
        res.entries = CNT_W'(set_fill);
        return res;
    endfunction

    // Request driver
    always @(posedge clk) begin
        int open_cnt;
        bit busy;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else begin
            busy     = s_tvalid;
            open_cnt = sent_cnt - recv_cnt - ((m_tvalid && m_tready) ? 1 : 0);
            if (s_tvalid && s_tready) begin
                expected_q.push_back(apply_request(cur_req));
                sent_cnt <= sent_cnt + 1;
                open_cnt++;
                busy = 1'b0;
            end
            if (busy) begin
                s_tvalid <= 1'b1;
            end
            else if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() != 0 && !(pending_q[0].drain && open_cnt != 0)) begin
                cur_req = pending_q.pop_front();
                s_tdata  <= {cur_req.pos, cur_req.key};
                s_tuser  <= cur_req.func;
                s_tvalid <= 1'b1;
                if (src_gaps && $urandom_range(0, 99) < 30)
                    gap_left = pick_gap();
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
            if (snk_stalls && $urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Result monitor
    always @(posedge clk) begin
        set_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            recv_cnt <= recv_cnt + 1;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: tuser 0x%0h tdata 0x%0h",
                       m_tuser, m_tdata);
                err_cnt++;
            end
            else begin
                want = expected_q.pop_front();
                check_field("status",  32'(want.status),  32'(m_tuser));
                check_field("slot",    32'(want.slot),    32'(m_tdata[8:0]));
                check_field("key_out", want.key_out,      m_tdata[40:9]);
                check_field("entries", 32'(want.entries), 32'(m_tdata[49:41]));
                check_field("pad",     32'd0,             32'(m_tdata[55:50]));
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_COUNT)
            set_limit = int'(value[8:0]);
    endtask

    // Wait until the request queue is empty and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || sent_cnt != recv_cnt);
    endtask

    task automatic push_req(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                            input logic [POS_W-1:0] pos, input bit drain = 1'b0);
        set_request_t rq;
        rq.func  = func;
        rq.key   = key;
        rq.pos   = pos;
        rq.drain = drain;
        pending_q.push_back(rq);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int reuse_pct);
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(0, 99);
        if (r < reuse_pct && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 8)
            k = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                             : $urandom_range(0, 3);
        else if (r < 55)
            k = KEY_W'($urandom_range(0, 1500));
        else
            k = $urandom;
        if (key_pool.size() < 64)
            key_pool.push_back(k);
        else
            key_pool[$urandom_range(0, 63)] = k;
        return k;
    endfunction

    // Queue n random requests with the given operation mix (rest are reads)
    task automatic queue_random(input int n, input int add_pct, input int rem_pct,
                                input int find_pct, input int reuse_pct);
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        int                r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                func = FUNC_ADD;
            else if (r < add_pct + rem_pct)
                func = FUNC_REMOVE;
            else if (r < add_pct + rem_pct + find_pct)
                func = FUNC_FIND;
            else
                func = FUNC_READ;
            pos = ($urandom_range(0, 1) != 0) ? POS_W'($urandom_range(0, 31))
                                              : POS_W'($urandom_range(0, 255));
            push_req(func, pick_key(reuse_pct), pos, $urandom_range(0, 199) == 0);
        end
    endtask

    task automatic start_phase(input int limit, input bit gaps, input bit stalls);
        wait_drained();
        write_reg(ADDR_MAX_COUNT, limit);
        src_gaps   = gaps;
        snk_stalls = stalls;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Small limit: empty set, extremes of the key, duplicate add, add when full
        start_phase(3, 1'b1, 1'b1);
        push_req(FUNC_READ,   32'h0,         8'd0);
        push_req(FUNC_FIND,   32'h0,         8'd0);
        push_req(FUNC_REMOVE, 32'h5,         8'd0);
        push_req(FUNC_ADD,    32'hFFFF_FFFF, 8'd0);
        push_req(FUNC_ADD,    32'h0,         8'd0);
        push_req(FUNC_ADD,    32'h0,         8'd0);
        push_req(FUNC_ADD,    32'h8000_0000, 8'd0);
        push_req(FUNC_ADD,    32'h7,         8'd0);
        push_req(FUNC_FIND,   32'hFFFF_FFFF, 8'd0, 1'b1);
        push_req(FUNC_FIND,   32'h8000_0001, 8'd0);
        push_req(FUNC_READ,   32'h0,         8'd2);
        push_req(FUNC_READ,   32'h0,         8'd3);
        push_req(FUNC_READ,   32'hFFFF_FFFF, 8'd255);
        push_req(FUNC_REMOVE, 32'h8000_0000, 8'd0);
        push_req(FUNC_REMOVE, 32'h8000_0000, 8'd0);

        // Zero limit, also below the fill: adds overflow, remove and read still work
        start_phase(0, 1'b0, 1'b1);
        push_req(FUNC_ADD,    32'h5,         8'd0);
        push_req(FUNC_FIND,   32'h0,         8'd0);
        push_req(FUNC_READ,   32'h0,         8'd0);
        push_req(FUNC_REMOVE, 32'h0,         8'd0);

        // Limit equal to the fill
        start_phase(1, 1'b1, 1'b0);
        push_req(FUNC_ADD,    32'h9,         8'd0);
        push_req(FUNC_READ,   32'h0,         8'd0);

        // Full limit: empty the set again
        start_phase(256, 1'b1, 1'b1);
        push_req(FUNC_REMOVE, 32'hFFFF_FFFF, 8'd0);
        push_req(FUNC_READ,   32'h0,         8'd0);

        // Fill toward the full store
        start_phase(256, 1'b1, 1'b1);
        queue_random(500, 75, 5, 10, 10);

        // Lower the limit, most likely below the fill
        start_phase($urandom_range(1, 255), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) != 0);
        queue_random(150, 30, 25, 25, 50);

        start_phase(0, 1'b0, 1'b0);
        queue_random(50, 40, 20, 20, 50);

        // Drain the set with mostly removes
        start_phase(256, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
        queue_random(200, 10, 55, 15, 70);

        start_phase($urandom_range(2, 40), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) != 0);
        queue_random(100, 35, 25, 20, 50);

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_sorted_key_set_engine OK");
        else
            $display("tb_sorted_key_set_engine NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_sorted_key_set_engine NOT OK");
        $finish;
    end

endmodule
